>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MD5_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("md5 assertion failed");
// When the antecedent holds, the consequent must hold in the next cycle.
`define MD5_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("md5 assertion failed");
`else
`define MD5_ASSERT(lbl, clk, rstn, prop)
`define MD5_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/md5_pkg.sv
package md5_pkg;

  localparam int BLOCK_BITS      = 512;
  localparam int BLOCK_WORDS     = 16;
  localparam int DIGEST_BITS     = 128;
  localparam int COUNT_BITS      = 61;
  localparam int LEN_FIRST       = 56;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_STEP = 6'd63;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // One 64-byte block on its way to the compression engine; byte j sits in data[8j+7:8j].
  typedef struct packed {
    logic                  last;
    logic [BLOCK_BITS-1:0] data;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {FS_TAKE, FS_PAD, FS_LEN} front_state_t;
  typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_FIN} core_state_t;

  function automatic logic [31:0] step_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/md5_queue.sv
// Small block queue between the byte front end and the compression engine.
module md5_queue #(
  parameter int DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  md5_pkg::blk_t   push_blk,
  input  logic            pop,
  output md5_pkg::blk_t   head_blk,
  output md5_pkg::q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  md5_pkg::blk_t   entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign head_blk   = entries_r[rd_ptr_r];
  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_blk;
    end
  end

endmodule

>>> rtl/md5_front.sv
// Byte front end: gathers message bytes into 64-byte blocks and builds the padding blocks.
module md5_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic             in_tuser,
  input  md5_pkg::q_stat_t q_stat,
  output logic             push,
  output md5_pkg::blk_t    push_blk
);

  md5_pkg::front_state_t         state_r, state_nxt;
  logic [md5_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [31:0]                   buf_r [md5_pkg::BLOCK_WORDS];

  logic [5:0]                    used;
  logic                          fits;
  logic                          wr_byte;
  logic [63:0]                   bit_len;
  logic [md5_pkg::BLOCK_BITS-1:0] flat, full_blk, pad_blk, len_blk;

  assign used    = count_r[5:0];
  assign fits    = (used < 6'(md5_pkg::LEN_FIRST));
  assign bit_len = {count_r, 3'b000};

  // Block images: the full block with the closing byte, the first padding
  // block and the length-only block that follows when the length no longer fits after the marker.
  always_comb begin
    flat = '0;
    for (int k = 0; k < md5_pkg::BLOCK_WORDS; k++) begin
      flat[32*k +: 32] = buf_r[k];
    end
    full_blk = flat;
    full_blk[md5_pkg::BLOCK_BITS-1 -: 8] = in_tdata;
    for (int j = 0; j < md5_pkg::BLOCK_BITS / 8; j++) begin
      if (6'(j) < used) begin
        pad_blk[8*j +: 8] = flat[8*j +: 8];
      end else if (6'(j) == used) begin
        pad_blk[8*j +: 8] = md5_pkg::PAD_MARK;
      end else if (fits && (j >= md5_pkg::LEN_FIRST)) begin
        pad_blk[8*j +: 8] = bit_len[8*(j%8) +: 8];
      end else begin
        pad_blk[8*j +: 8] = 8'h00;
      end
      len_blk[8*j +: 8] = (j >= md5_pkg::LEN_FIRST) ? bit_len[8*(j%8) +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    push          = 1'b0;
    wr_byte       = 1'b0;
    push_blk.last = 1'b0;
    push_blk.data = full_blk;
    in_tready     = (state_r == md5_pkg::FS_TAKE) && !q_stat.full;
    case (state_r)
      md5_pkg::FS_TAKE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser) begin
            wr_byte   = 1'b1;
            count_nxt = count_r + md5_pkg::COUNT_BITS'(1);
            push      = (used == md5_pkg::LAST_BYTE);
          end
          if (in_tlast) begin
            state_nxt = md5_pkg::FS_PAD;
          end
        end
      end
      md5_pkg::FS_PAD: begin
        if (!q_stat.full) begin
          push          = 1'b1;
          push_blk.data = pad_blk;
          if (fits) begin
            push_blk.last = 1'b1;
            count_nxt     = '0;
            state_nxt     = md5_pkg::FS_TAKE;
          end else begin
            state_nxt     = md5_pkg::FS_LEN;
          end
        end
      end
      md5_pkg::FS_LEN: begin
        if (!q_stat.full) begin
          push          = 1'b1;
          push_blk.data = len_blk;
          push_blk.last = 1'b1;
          count_nxt     = '0;
          state_nxt     = md5_pkg::FS_TAKE;
        end
      end
      default: begin
        state_nxt = md5_pkg::FS_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5_pkg::FS_TAKE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_byte) begin
      buf_r[used[5:2]][{used[1:0], 3'b000} +: 8] <= in_tdata;
    end
  end

endmodule

>>> rtl/md5_core.sv
// Compression engine: one MD5 step per cycle, chaining update and digest register.
module md5_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  md5_pkg::blk_t                   head_blk,
  input  md5_pkg::q_stat_t                q_stat,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [md5_pkg::DIGEST_BITS-1:0] out_tdata
);

  md5_pkg::core_state_t state_r, state_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] chain_r [4];
  logic [31:0] w_r [md5_pkg::BLOCK_WORDS];
  logic        last_r;
  logic        out_valid_r, out_valid_nxt;
  logic [md5_pkg::DIGEST_BITS-1:0] out_data_r;

  logic        load, adv, chain_upd, chain_init, emit;
  logic [3:0]  i4, g;
  logic [31:0] f, sum, new_b;
  logic [63:0] dbl;
  logic [31:0] sa, sb, sc, sd;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sa = chain_r[0] + a_r;
  assign sb = chain_r[1] + b_r;
  assign sc = chain_r[2] + c_r;
  assign sd = chain_r[3] + d_r;

  // One step: round function, message word pick, add, rotate left.
  always_comb begin
    i4 = step_r[3:0];
    case (step_r[5:4])
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = i4;
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        g = i4 * 4'd5 + 4'd1;
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = i4 * 4'd3 + 4'd5;
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = i4 * 4'd7;
      end
    endcase
    sum   = a_r + f + w_r[g] + md5_pkg::step_const(step_r);
    dbl   = {sum, sum} << md5_pkg::rot_amount({step_r[5:4], step_r[1:0]});
    new_b = b_r + dbl[63:32];
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pop           = 1'b0;
    load          = 1'b0;
    adv           = 1'b0;
    chain_upd     = 1'b0;
    chain_init    = 1'b0;
    emit          = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      md5_pkg::CS_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          load      = 1'b1;
          step_nxt  = '0;
          state_nxt = md5_pkg::CS_RUN;
        end
      end
      md5_pkg::CS_RUN: begin
        adv      = 1'b1;
        step_nxt = step_r + 6'd1;
        if (step_r == md5_pkg::LAST_STEP) begin
          state_nxt = md5_pkg::CS_FIN;
        end
      end
      md5_pkg::CS_FIN: begin
        if (!last_r) begin
          chain_upd = 1'b1;
          state_nxt = md5_pkg::CS_IDLE;
        end else if (!out_valid_r || out_tready) begin
          emit          = 1'b1;
          chain_init    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = md5_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = md5_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5_pkg::CS_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= md5_pkg::IV_A;
      chain_r[1]  <= md5_pkg::IV_B;
      chain_r[2]  <= md5_pkg::IV_C;
      chain_r[3]  <= md5_pkg::IV_D;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (chain_init) begin
        chain_r[0] <= md5_pkg::IV_A;
        chain_r[1] <= md5_pkg::IV_B;
        chain_r[2] <= md5_pkg::IV_C;
        chain_r[3] <= md5_pkg::IV_D;
      end else if (chain_upd) begin
        chain_r[0] <= sa;
        chain_r[1] <= sb;
        chain_r[2] <= sc;
        chain_r[3] <= sd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r    <= chain_r[0];
      b_r    <= chain_r[1];
      c_r    <= chain_r[2];
      d_r    <= chain_r[3];
      last_r <= head_blk.last;
      for (int k = 0; k < md5_pkg::BLOCK_WORDS; k++) begin
        w_r[k] <= head_blk.data[32*k +: 32];
      end
    end else if (adv) begin
      a_r <= d_r;
      b_r <= new_b;
      c_r <= b_r;
      d_r <= c_r;
    end
    if (emit) begin
      out_data_r <= {sd, sc, sb, sa};
    end
  end

endmodule

>>> rtl/md5_message_digest.sv
// After the last beat, the digest follows once the engine has worked through any blocks already
// queued and then the one or two padding blocks of the message.
// Throughput: one byte per cycle while the block queue has room and no padding block is being
// written; per 64-byte block the engine loads it, runs 64 steps and updates the chaining words.
// Reset: synchronous, active low; clears the byte count, queue and state, and loads the MD5
// initial chaining words. The block buffer and queue contents are not reset.

`include "assert_macros.svh"

// Streaming MD5 hasher. The front end collects message bytes, one per beat with byte_present set,
// into a 64-byte buffer. Each full buffer, and after the beat marked last the one or two padding
// blocks (0x80 marker, zeros, 64-bit little-endian bit length), goes into a short block queue. The
// compression engine takes blocks from the queue and runs the 64 MD5 steps, one per cycle,
// then folds the result into the chaining words. After the final block of a message, the
// 16-byte digest is placed in the output register and the chaining words return to their
// initial values, so the next message can follow straight away.
//
// The queue lets the front end keep taking bytes while the engine is busy with an earlier
// block; the engine in turn only stalls when a digest waits in the output register.
module md5_message_digest #(
  parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_message
  input  logic         in_tuser,   // [0] byte_present
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [63:0] digest_first_half, [127:64] digest_second_half
);

  md5_pkg::blk_t    push_blk;
  md5_pkg::blk_t    head_blk;
  md5_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  // Front end: byte collection and padding.
  md5_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_blk  (push_blk)
  );

  // Block queue between the two halves.
  md5_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_blk (push_blk),
    .pop      (q_pop),
    .head_blk (head_blk),
    .stat     (q_stat)
  );

  // Compression engine and digest output register.
  md5_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_blk   (head_blk),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The front end must never write a block into a full queue.
  `MD5_ASSERT(a_no_push_when_full, clk, rst_n, !(q_push && q_stat.full))
  // The engine must never take a block from an empty queue.
  `MD5_ASSERT(a_no_pop_when_empty, clk, rst_n, !(q_pop && q_stat.empty))
  // In the cycle after the final beat of a message the front end is busy padding and takes no bytes.
  `MD5_ASSERT_NEXT(a_pad_after_last, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready)

endmodule
